[rtl/core/stdf_pkg.sv]
// ----------------------------------------------------------------------------
// stdf_pkg
// Shared types, codes and the crc step for the scanner telegram deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package stdf_pkg;

  localparam logic [15:0] CRC_POLY       = 16'h8005;
  localparam logic [7:0]  START_BYTE     = 8'h02;
  localparam logic [7:0]  ADDR_BYTE      = 8'h80;
  localparam int unsigned OVERHEAD       = 6;
  localparam int unsigned MIN_CAPACITY   = 7;
  localparam int unsigned HDR_BYTES      = 3;
  localparam int unsigned MAX_LEN_W      = 11;
  localparam int unsigned MAX_LEN_RESET  = 1024;
  localparam int unsigned INDEX_W        = 10;
  localparam int unsigned FLEN_W         = 17;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned ADDR_W         = 3;
  localparam logic        REG_MAX_LENGTH = 1'b0;
  localparam int unsigned Q_DEPTH        = 2;
  localparam int unsigned Q_PTR_W        = 1;
  localparam int unsigned Q_CNT_W        = 2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CAP_LOW   = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_ADDR  = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_CRC_ERR   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_FEED  = 2'd0,
    OP_LOW   = 2'd1,
    OP_CHECK = 2'd2,
    OP_ABORT = 2'd3
  } op_e;

  typedef struct packed {
    logic [7:0]         data;
    logic [INDEX_W-1:0] index;
    logic               done;
    status_e            status;
    logic [FLEN_W-1:0]  flen;
    op_e                op;
  } item_t;

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b,
                                           input logic [7:0] prev);
    logic [15:0] c;
    c = {acc[14:0], 1'b0};
    if (acc[15]) begin
      c = c ^ CRC_POLY;
    end
    return c ^ {prev, b};
  endfunction

endpackage

`default_nettype wire

[rtl/core/stdf_if.sv]
// ----------------------------------------------------------------------------
// stdf_if
// Byte and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface stdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface stdf_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [9:0]  byte_index;
  logic        frame_done;
  logic [2:0]  status;
  logic [16:0] frame_length;

  modport source (output valid, output out_byte, output byte_index, output frame_done,
                  output status, output frame_length, input ready);
  modport sink   (input valid, input out_byte, input byte_index, input frame_done,
                  input status, input frame_length, output ready);
endinterface

`default_nettype wire

[rtl/core/stdf_front.sv]
// ----------------------------------------------------------------------------
// stdf_front
// Accepts bytes, tracks telegram position and checks the header.
// ----------------------------------------------------------------------------
`default_nettype none

module stdf_front #(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  stdf_byte_if.sink                           rx_i,
  input  wire logic [stdf_pkg::MAX_LEN_W-1:0] max_length_i,
  output logic                                push_o,
  input  wire logic                           push_ready_i,
  output stdf_pkg::item_t                     item_o
);

  localparam int unsigned CntW = $clog2(BUFFER_BYTES);
  localparam logic PH_HEADER = 1'b0;
  localparam logic PH_BODY   = 1'b1;

  logic                          phase_q, phase_d;
  logic [CntW-1:0]               count_q, count_d;
  logic [stdf_pkg::FLEN_W-1:0]   total_q, total_d;
  logic [7:0]                    hdr_q [stdf_pkg::HDR_BYTES];
  logic                          hdr_we;
  logic                          accept;
  logic [stdf_pkg::FLEN_W-1:0]   pos_ext;
  logic [stdf_pkg::FLEN_W-1:0]   cap;
  logic [stdf_pkg::FLEN_W-1:0]   len;
  logic [stdf_pkg::FLEN_W-1:0]   ml_ext;

  assign rx_i.ready = push_ready_i;
  assign push_o     = rx_i.valid;
  assign accept     = rx_i.valid & push_ready_i;

  assign pos_ext = stdf_pkg::FLEN_W'(count_q);
  assign ml_ext  = stdf_pkg::FLEN_W'(max_length_i);
  assign cap     = (ml_ext > stdf_pkg::FLEN_W'(BUFFER_BYTES)) ?
                   stdf_pkg::FLEN_W'(BUFFER_BYTES) : ml_ext;
  assign len     = stdf_pkg::FLEN_W'(stdf_pkg::OVERHEAD) + stdf_pkg::FLEN_W'(hdr_q[2])
                 + {1'b0, rx_i.rx_byte, 8'h00};

  always_comb begin
    item_o.data   = rx_i.rx_byte;
    item_o.index  = pos_ext[stdf_pkg::INDEX_W-1:0];
    item_o.done   = 1'b0;
    item_o.status = stdf_pkg::ST_OK;
    item_o.flen   = '0;
    item_o.op     = stdf_pkg::OP_FEED;
    phase_d       = phase_q;
    count_d       = count_q;
    total_d       = total_q;
    hdr_we        = 1'b0;
    unique case (phase_q)
      PH_HEADER: begin
        if (pos_ext < stdf_pkg::FLEN_W'(stdf_pkg::HDR_BYTES)) begin
          hdr_we  = 1'b1;
          count_d = count_q + 1'b1;
        end else begin
          item_o.flen = len;
          if (cap < stdf_pkg::FLEN_W'(stdf_pkg::MIN_CAPACITY)) begin
            item_o.status = stdf_pkg::ST_CAP_LOW;
          end else if (hdr_q[0] != stdf_pkg::START_BYTE) begin
            item_o.status = stdf_pkg::ST_BAD_START;
          end else if (hdr_q[1] != stdf_pkg::ADDR_BYTE) begin
            item_o.status = stdf_pkg::ST_BAD_ADDR;
          end else if (len > cap) begin
            item_o.status = stdf_pkg::ST_TOO_LONG;
          end
          if (item_o.status != stdf_pkg::ST_OK) begin
            item_o.done = 1'b1;
            item_o.op   = stdf_pkg::OP_ABORT;
            count_d     = '0;
          end else begin
            total_d = len;
            count_d = CntW'(stdf_pkg::HDR_BYTES + 1);
            phase_d = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        item_o.flen = total_q;
        if ((pos_ext + 2'd2) < total_q) begin
          count_d = count_q + 1'b1;
        end else if ((pos_ext + 2'd2) == total_q) begin
          item_o.op = stdf_pkg::OP_LOW;
          count_d   = count_q + 1'b1;
        end else begin
          item_o.done = 1'b1;
          item_o.op   = stdf_pkg::OP_CHECK;
          count_d     = '0;
          total_d     = '0;
          phase_d     = PH_HEADER;
        end
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      count_q <= '0;
      total_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hdr_we) begin
      hdr_q[count_q[1:0]] <= rx_i.rx_byte;
    end
  end

endmodule

`default_nettype wire

[rtl/core/stdf_queue.sv]
// ----------------------------------------------------------------------------
// stdf_queue
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module stdf_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 push_ready_o,
  input  wire stdf_pkg::item_t push_item_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_i,
  output stdf_pkg::item_t      pop_item_o
);

  stdf_pkg::item_t              mem_q [stdf_pkg::Q_DEPTH];
  logic [stdf_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [stdf_pkg::Q_CNT_W-1:0] cnt_q;
  logic                         do_push, do_pop;

  assign push_ready_o = (cnt_q != stdf_pkg::Q_CNT_W'(stdf_pkg::Q_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/stdf_back.sv]
// ----------------------------------------------------------------------------
// stdf_back
// Runs the crc over classified bytes and registers each result.
// ----------------------------------------------------------------------------
`default_nettype none

module stdf_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            pop_valid_i,
  output logic                 pop_o,
  input  wire stdf_pkg::item_t item_i,
  stdf_result_if.source        res_o
);

  logic [15:0]       crc_q, crc_d;
  logic [7:0]        prev_q, prev_d;
  logic [7:0]        low_q, low_d;
  logic              valid_q;
  logic              take;
  stdf_pkg::status_e status_d;
  stdf_pkg::status_e status_q;
  logic [7:0]        byte_q;
  logic [9:0]        index_q;
  logic              done_q;
  logic [16:0]       flen_q;

  assign pop_o = pop_valid_i & (~valid_q | res_o.ready);
  assign take  = pop_o;

  always_comb begin
    crc_d    = crc_q;
    prev_d   = prev_q;
    low_d    = low_q;
    status_d = item_i.status;
    unique case (item_i.op)
      stdf_pkg::OP_FEED: begin
        crc_d  = stdf_pkg::crc_step(crc_q, item_i.data, prev_q);
        prev_d = item_i.data;
      end
      stdf_pkg::OP_LOW: begin
        low_d = item_i.data;
      end
      stdf_pkg::OP_CHECK: begin
        if ((low_q != crc_q[7:0]) || (item_i.data != crc_q[15:8])) begin
          status_d = stdf_pkg::ST_CRC_ERR;
        end
        crc_d  = '0;
        prev_d = '0;
        low_d  = '0;
      end
      stdf_pkg::OP_ABORT: begin
        crc_d  = '0;
        prev_d = '0;
        low_d  = '0;
      end
      default: begin
        crc_d = crc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= '0;
      prev_q  <= '0;
      low_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (take) begin
        crc_q   <= crc_d;
        prev_q  <= prev_d;
        low_q   <= low_d;
        valid_q <= 1'b1;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q   <= item_i.data;
      index_q  <= item_i.index;
      done_q   <= item_i.done;
      status_q <= status_d;
      flen_q   <= item_i.flen;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.out_byte     = byte_q;
  assign res_o.byte_index   = index_q;
  assign res_o.frame_done   = done_q;
  assign res_o.status       = status_q;
  assign res_o.frame_length = flen_q;

endmodule

`default_nettype wire

[rtl/core/scanner_telegram_deframer.sv]
// ----------------------------------------------------------------------------
// scanner_telegram_deframer
// Deframes scanner telegrams byte by byte and checks header and crc-16.
// ----------------------------------------------------------------------------
// path: an accepted byte is written into the queue, then taken into the back end's result register
// throughput: one byte per cycle while the output is ready; the crc step in the back end is combinational
// the two-entry queue lets input accept up to two bytes while a result waits at the output
// reset: framing and crc state cleared, max_length set to 1024, no clearing pass
`default_nettype none

module scanner_telegram_deframer #(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  stdf_byte_if.sink                          rx_i,
  stdf_result_if.source                      res_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [stdf_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [stdf_pkg::DATA_W-1:0]   pwdata,
  output logic      [stdf_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  logic [stdf_pkg::MAX_LEN_W-1:0] max_length_q;
  logic                           push;
  logic                           push_ready;
  stdf_pkg::item_t                push_item;
  logic                           pop_valid;
  logic                           pop;
  stdf_pkg::item_t                pop_item;
  logic                           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[stdf_pkg::ADDR_W-1] == stdf_pkg::REG_MAX_LENGTH);
  assign prdata  = reg_sel ? stdf_pkg::DATA_W'(max_length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= stdf_pkg::MAX_LEN_W'(stdf_pkg::MAX_LEN_RESET);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_length_q <= pwdata[stdf_pkg::MAX_LEN_W-1:0];
    end
  end

  stdf_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .max_length_i (max_length_q),
    .push_o       (push),
    .push_ready_i (push_ready),
    .item_o       (push_item)
  );

  stdf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  stdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .item_i      (pop_item),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
